### rtl/utf8_punctuation_tokenizer_assert.svh
// Assertion macros for the UTF-8 delimiter tokenizer checker.
`ifndef UTF8_PUNCTUATION_TOKENIZER_ASSERT_SVH
`define UTF8_PUNCTUATION_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define UTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define UTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

### rtl/utp_pkg.sv
// Shared types and constants of the UTF-8 delimiter tokenizer.
`timescale 1ns / 1ps

package utp_pkg;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_HIGH = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_start;
    logic       is_status;
    logic       utf8_invalid;
    logic       last_result;
  } result_t;

  // One classified byte: an optional token byte and an optional status.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       emit;
    logic       token_start;
    logic       final_byte;
    logic       utf8_invalid;
  } entry_t;

endpackage

### rtl/utf8_punctuation_tokenizer.sv
// Top level of the UTF-8 delimiter tokenizer.
`timescale 1ns / 1ps
//
//  channel | ports                           | transfer when
//  --------+---------------------------------+-------------------------
//  input   | in_push, in_full, in_data       | in_push && !in_full
//  result  | out_empty, out_pop, out_data    | out_pop && !out_empty
//  config  | cfg_valid, cfg_ready, cfg_index,| cfg_valid && cfg_ready
//          | cfg_wdata                       |
//
//  One byte is taken per cycle while in_full is low; the front end
//  classifies it in the cycle it arrives and queues one entry (none for an
//  escape or a non-final delimiter). The result stage hands out one result
//  per cycle while out_pop is high; a final token byte: byte, then status.
//  in_full rises only when the QUEUE_DEPTH-entry queue is full.
//  Synchronous active-low reset clears the text state, the queue and both
//  delimiter maps. cfg_ready is always high; writes take effect next cycle.
//
module utf8_punctuation_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = utp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input byte stream
  input  logic                          in_push,
  output logic                          in_full,
  input  utp_pkg::item_t                in_data,
  // result stream
  output logic                          out_empty,
  input  logic                          out_pop,
  output utp_pkg::result_t              out_data,
  // delimiter map writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [utp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);

  logic            q_push, q_pop, q_full, q_empty;
  utp_pkg::entry_t q_wdata, q_head;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;

  // Front end: owns the delimiter maps and all per-text state. It advances
  // on every accepted byte regardless of what the result side is doing.
  utp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Decoupling queue; one entry per classified byte that yields a result.
  utp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // Result stage: an entry leaves the queue once its last result transfers.
  utp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

### rtl/utp_front.sv
// Front end: delimiter maps, UTF-8 check and token classification per byte.
`timescale 1ns / 1ps

module utp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  utp_pkg::item_t                 in_data,
  input  logic                           q_full,
  output logic                           q_push,
  output utp_pkg::entry_t                q_wdata,
  input  logic                           cfg_valid,
  input  logic [utp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_wdata
);

  // Constraint on the next continuation byte.
  typedef enum logic [2:0] {
    RNG_ANY   = 3'd0,
    RNG_A0_BF = 3'd1,
    RNG_80_9F = 3'd2,
    RNG_90_BF = 3'd3,
    RNG_80_8F = 3'd4
  } range_t;

  logic [127:0] delim_map_r;
  logic         esc_pend_r, esc_pend_nxt;
  logic         in_token_r, in_token_nxt;
  logic [1:0]   cont_left_r, cont_left_nxt;
  range_t       range_r, range_nxt;
  logic         err_r, err_nxt;

  logic [7:0]   b;
  logic         fin;
  logic         accept;
  logic [7:0]   lo, hi;
  logic         lead_chk;
  logic         is_dl, bs_dl;
  logic         emit, start;

  assign b      = in_data.text_byte;
  assign fin    = in_data.final_byte;
  assign accept = in_push && !q_full;

  assign is_dl = !b[7] && delim_map_r[b[6:0]];
  assign bs_dl = delim_map_r[utp_pkg::BACKSLASH[6:0]];

  // UTF-8 sequence tracking
  always_comb begin
    cont_left_nxt = cont_left_r;
    range_nxt     = range_r;
    err_nxt       = err_r;
    lead_chk      = 1'b1;
    lo            = 8'h80;
    hi            = 8'hBF;
    case (range_r)
      RNG_A0_BF: lo = 8'hA0;
      RNG_80_9F: hi = 8'h9F;
      RNG_90_BF: lo = 8'h90;
      RNG_80_8F: hi = 8'h8F;
      default: ;
    endcase
    if (cont_left_r != 2'd0) begin
      if (b >= lo && b <= hi) begin
        cont_left_nxt = cont_left_r - 2'd1;
        range_nxt     = RNG_ANY;
        lead_chk      = 1'b0;
      end else begin
        err_nxt = 1'b1;
      end
    end
    // a byte that breaks a sequence is rechecked as a lead byte
    if (lead_chk) begin
      cont_left_nxt = 2'd0;
      range_nxt     = RNG_ANY;
      unique case (b) inside
        [8'h00:8'h7F]: ;
        [8'hC2:8'hDF]: cont_left_nxt = 2'd1;
        8'hE0: begin
          cont_left_nxt = 2'd2;
          range_nxt     = RNG_A0_BF;
        end
        8'hED: begin
          cont_left_nxt = 2'd2;
          range_nxt     = RNG_80_9F;
        end
        [8'hE1:8'hEC], [8'hEE:8'hEF]: cont_left_nxt = 2'd2;
        8'hF0: begin
          cont_left_nxt = 2'd3;
          range_nxt     = RNG_90_BF;
        end
        8'hF4: begin
          cont_left_nxt = 2'd3;
          range_nxt     = RNG_80_8F;
        end
        [8'hF1:8'hF3]: cont_left_nxt = 2'd3;
        default: err_nxt = 1'b1;
      endcase
    end
    // truncated sequence at end of text
    if (fin && cont_left_nxt != 2'd0) begin
      err_nxt = 1'b1;
    end
  end

  // Escape and token boundaries
  always_comb begin
    esc_pend_nxt = esc_pend_r;
    in_token_nxt = in_token_r;
    emit         = 1'b0;
    start        = 1'b0;
    if (esc_pend_r) begin
      esc_pend_nxt = 1'b0;
      emit         = 1'b1;
      start        = (b != utp_pkg::BACKSLASH && !is_dl && bs_dl) || !in_token_r;
    end else if (b == utp_pkg::BACKSLASH && !fin) begin
      esc_pend_nxt = 1'b1;
    end else if (is_dl) begin
      in_token_nxt = 1'b0;
    end else begin
      emit  = 1'b1;
      start = !in_token_r;
    end
    if (emit) begin
      in_token_nxt = 1'b1;
    end
  end

  assign q_push                = accept && (emit || fin);
  assign q_wdata.text_byte     = b;
  assign q_wdata.emit          = emit;
  assign q_wdata.token_start   = start;
  assign q_wdata.final_byte    = fin;
  assign q_wdata.utf8_invalid  = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r  <= 1'b0;
      in_token_r  <= 1'b0;
      cont_left_r <= 2'd0;
      range_r     <= RNG_ANY;
      err_r       <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        esc_pend_r  <= 1'b0;
        in_token_r  <= 1'b0;
        cont_left_r <= 2'd0;
        range_r     <= RNG_ANY;
        err_r       <= 1'b0;
      end else begin
        esc_pend_r  <= esc_pend_nxt;
        in_token_r  <= in_token_nxt;
        cont_left_r <= cont_left_nxt;
        range_r     <= range_nxt;
        err_r       <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_map_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        utp_pkg::CFG_DELIM_LOW:  delim_map_r[63:0]   <= cfg_wdata;
        utp_pkg::CFG_DELIM_HIGH: delim_map_r[127:64] <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### rtl/utp_fifo.sv
// Small register-file queue between the front end and the result stage.
`timescale 1ns / 1ps

module utp_fifo #(
  parameter int unsigned DEPTH = utp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utp_pkg::entry_t wdata,
  input  logic            pop,
  output utp_pkg::entry_t rdata,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utp_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/utp_back.sv
// Result stage: expands a queued entry into its token byte and status results.
`timescale 1ns / 1ps

module utp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  utp_pkg::entry_t   head,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output utp_pkg::result_t  out_data
);

  // set once the token byte of a two-result entry has been transferred
  logic phase_r;
  logic two_res;
  logic show_tok;
  logic xfer;

  assign two_res   = head.emit && head.final_byte;
  assign show_tok  = head.emit && !phase_r;
  assign out_empty = q_empty;
  assign xfer      = out_pop && !q_empty;
  assign q_pop     = xfer && !(two_res && !phase_r);

  always_comb begin
    if (show_tok) begin
      out_data.out_byte     = head.text_byte;
      out_data.token_start  = head.token_start;
      out_data.is_status    = 1'b0;
      out_data.utf8_invalid = 1'b0;
      out_data.last_result  = !head.final_byte;
    end else begin
      out_data.out_byte     = 8'h00;
      out_data.token_start  = 1'b0;
      out_data.is_status    = 1'b1;
      out_data.utf8_invalid = head.utf8_invalid;
      out_data.last_result  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (xfer) begin
      phase_r <= two_res && !phase_r;
    end
  end

endmodule

### rtl/utp_checker.sv
// Port-level checker for the UTF-8 delimiter tokenizer, with its bind.
`timescale 1ns / 1ps
`include "utf8_punctuation_tokenizer_assert.svh"

module utp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  utp_pkg::item_t                in_data,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  utp_pkg::result_t              out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [utp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);

  // status results carry no byte and always close their step
  `UTP_ASSERT_IMP(a_status_shape, !out_empty && out_data.is_status, out_data.out_byte == 8'h00 && !out_data.token_start && out_data.last_result)

  // token bytes never carry the invalid flag
  `UTP_ASSERT_IMP(a_token_valid_flag, !out_empty && !out_data.is_status, !out_data.utf8_invalid)

  // a token byte that is not last is directly followed by its status
  `UTP_ASSERT_NXT(a_status_follows, !out_empty && out_pop && !out_data.is_status && !out_data.last_result, !out_empty && out_data.is_status)

  // a waiting result stays put until it transfers
  `UTP_ASSERT_NXT(a_result_held, !out_empty && !out_pop, !out_empty && $stable(out_data))

endmodule

bind utf8_punctuation_tokenizer utp_checker u_checker (.*);

### tb/sv/utf8_punctuation_tokenizer_checker.sv
// Checker for the UTF-8 delimiter tokenizer: predicts token bytes and status, compares results.
`timescale 1ns / 1ps

module utf8_punctuation_tokenizer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  utp_pkg::item_t                in_data,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  utp_pkg::result_t              out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [utp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  output int unsigned                   fail_count,
  output int unsigned                   results_due
);

  // constraint on the next continuation byte
  typedef enum logic [2:0] {
    CONT_ANY,
    CONT_A0_BF,
    CONT_80_9F,
    CONT_90_BF,
    CONT_80_8F
  } cont_range_t;

  logic [63:0]      delim_lo, delim_hi;
  logic             esc_pending, in_tok, err_seen;
  logic [1:0]       cont_left;
  cont_range_t      cont_range;
  utp_pkg::result_t token_results[$];
  int unsigned      mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic is_delim(input logic [7:0] b);
    if (b < 8'd64) return delim_lo[b[5:0]];
    if (b < 8'd128) return delim_hi[b[5:0]];
    return 1'b0;
  endfunction

  task automatic queue_result(input utp_pkg::result_t r);
    token_results.insert(token_results.size(), r);
  endtask

  task automatic reset_text();
    esc_pending = 1'b0;
    in_tok      = 1'b0;
    err_seen    = 1'b0;
    cont_left   = 2'd0;
    cont_range  = CONT_ANY;
  endtask

  task automatic take_lead(input logic [7:0] b);
    cont_left  = 2'd0;
    cont_range = CONT_ANY;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      cont_left = 2'd1;
    end else if (b == 8'hE0) begin
      cont_left = 2'd2; cont_range = CONT_A0_BF;
    end else if (b == 8'hED) begin
      cont_left = 2'd2; cont_range = CONT_80_9F;
    end else if (b >= 8'hE1 && b <= 8'hEF) begin
      cont_left = 2'd2;
    end else if (b == 8'hF0) begin
      cont_left = 2'd3; cont_range = CONT_90_BF;
    end else if (b == 8'hF4) begin
      cont_left = 2'd3; cont_range = CONT_80_8F;
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      cont_left = 2'd3;
    end else if (b[7]) begin
      err_seen = 1'b1;
    end
  endtask

  task automatic predict_byte(input utp_pkg::item_t it);
    logic [7:0]       b, lo, hi;
    logic             fin, emit, start, split, taken;
    utp_pkg::result_t r;
    b     = it.text_byte;
    fin   = it.final_byte;
    emit  = 1'b0;
    start = 1'b0;
    taken = 1'b0;
    // UTF-8 validity: expected continuation, else rechecked as a lead byte
    if (cont_left != 2'd0) begin
      lo = 8'h80;
      hi = 8'hBF;
      case (cont_range)
        CONT_A0_BF: lo = 8'hA0;
        CONT_80_9F: hi = 8'h9F;
        CONT_90_BF: lo = 8'h90;
        CONT_80_8F: hi = 8'h8F;
        default:    ;
      endcase
      if (b >= lo && b <= hi) begin
        cont_left  = cont_left - 2'd1;
        cont_range = CONT_ANY;
        taken      = 1'b1;
      end else begin
        err_seen = 1'b1;
      end
    end
    if (!taken) take_lead(b);
    if (fin && cont_left != 2'd0) err_seen = 1'b1;

    if (esc_pending) begin
      // escaped code point is kept; may open a token of its own
      split       = b != utp_pkg::BACKSLASH && !is_delim(b) && is_delim(utp_pkg::BACKSLASH);
      esc_pending = 1'b0;
      emit        = 1'b1;
      start       = split || !in_tok;
    end else if (b == utp_pkg::BACKSLASH && !fin) begin
      esc_pending = 1'b1;
    end else if (!b[7] && is_delim(b)) begin
      in_tok = 1'b0;
    end else begin
      emit  = 1'b1;
      start = !in_tok;
    end

    if (emit) begin
      in_tok         = 1'b1;
      r.out_byte     = b;
      r.token_start  = start;
      r.is_status    = 1'b0;
      r.utf8_invalid = 1'b0;
      r.last_result  = !fin;
      queue_result(r);
    end
    if (fin) begin
      r.out_byte     = 8'h00;
      r.token_start  = 1'b0;
      r.is_status    = 1'b1;
      r.utf8_invalid = err_seen;
      r.last_result  = 1'b1;
      queue_result(r);
      reset_text();
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] got,
                               inout logic bad);
    if (got !== want) begin
      bad = 1'b1;
      $error("%s expected 0x%0h actual 0x%0h", field, want, got);
    end
  endtask

  task automatic check_result(input utp_pkg::result_t got);
    utp_pkg::result_t want;
    logic             bad;
    bad = 1'b0;
    if (token_results.size() == 0) begin
      $error("unexpected result 0x%0h", got);
      mismatches++;
      return;
    end
    want = token_results.pop_front();
    compare_field("out_byte", want.out_byte, got.out_byte, bad);
    compare_field("token_start", {7'd0, want.token_start}, {7'd0, got.token_start}, bad);
    compare_field("is_status", {7'd0, want.is_status}, {7'd0, got.is_status}, bad);
    compare_field("utf8_invalid", {7'd0, want.utf8_invalid}, {7'd0, got.utf8_invalid}, bad);
    compare_field("last_result", {7'd0, want.last_result}, {7'd0, got.last_result}, bad);
    if (bad) mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      delim_lo = '0;
      delim_hi = '0;
      reset_text();
      token_results.delete();
    end else begin
      // a byte taken on the same edge as a map write still sees the old map
      if (in_push && !in_full) predict_byte(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          utp_pkg::CFG_DELIM_LOW:  delim_lo = cfg_wdata;
          utp_pkg::CFG_DELIM_HIGH: delim_hi = cfg_wdata;
          default:                 ;
        endcase
      end
      if (out_pop && !out_empty) check_result(out_data);
    end
    results_due <= token_results.size();
  end

endmodule

### tb/sv/tb.sv
// Testbench top for the UTF-8 delimiter tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  // generous bound: ~1050 bytes at up to two results each, plus stalls and drains
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // queue depth plus margin for bytes that leave no result behind
  localparam int unsigned SETTLE_CYCLES = utp_pkg::QUEUE_DEPTH + 8;
  localparam int unsigned PHASE_BYTES   = 172;
  localparam int unsigned IDLE_PCT      = 6;

  // whitespace and punctuation: NUL, TAB, LF, CR, space, comma, period, colon, semicolon
  localparam logic [63:0] PUNCT_LOW = 64'h0C00_5001_0000_2601;
  // '@', '[', backslash, ']', '{', '|', '}'
  localparam logic [63:0] BS_BIT          = 64'h0000_0000_1000_0000;
  localparam logic [63:0] PUNCT_HIGH_NOBS = 64'h3800_0000_2800_0001;
  localparam logic [63:0] PUNCT_HIGH      = PUNCT_HIGH_NOBS | BS_BIT;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  utp_pkg::item_t                in_data = '0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  utp_pkg::result_t              out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [utp_pkg::CFG_IDX_W-1:0] cfg_index = utp_pkg::CFG_DELIM_LOW;
  logic [63:0]                   cfg_wdata = '0;

  int unsigned fail_count, results_due;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  logic        steady = 1'b0;   // no idling on either side while set
  logic [7:0]  text_q[$];

  always #2 clk = ~clk;

  utf8_punctuation_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  utf8_punctuation_tokenizer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Result side: pop most cycles, stall now and then unless in the steady phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[utf8_punctuation_tokenizer] ERROR");
      $finish;
    end
  end

  // One byte transfer. push stays high across back-to-back bytes; it drops only on a gap.
  task automatic send_item(input logic [7:0] b, input logic fin);
    utp_pkg::item_t nxt;
    nxt.text_byte  = b;
    nxt.final_byte = fin;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= nxt;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  // Both delimiter maps in one burst; valid drops once both transfers are done.
  task automatic load_maps(input logic [63:0] lo, input logic [63:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= utp_pkg::CFG_DELIM_LOW;
    cfg_wdata <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= utp_pkg::CFG_DELIM_HIGH;
    cfg_wdata <= hi;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Hold off input until every expected result is out, then let dropped bytes settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  // Well-formed multibyte code point, including the lead bytes with narrowed second ranges.
  task automatic add_multibyte();
    int unsigned len, sel;
    len = $urandom_range(4, 2);
    sel = $urandom_range(3);
    case (len)
      2: add_byte(8'($urandom_range(8'hDF, 8'hC2)));
      3: begin
        if (sel == 0) begin
          add_byte(8'hE0);
          add_byte(8'($urandom_range(8'hBF, 8'hA0)));
        end else if (sel == 1) begin
          add_byte(8'hED);
          add_byte(8'($urandom_range(8'h9F, 8'h80)));
        end else begin
          add_byte(8'($urandom_range(8'hEC, 8'hE1)));
          add_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
      end
      default: begin
        if (sel == 0) begin
          add_byte(8'hF0);
          add_byte(8'($urandom_range(8'hBF, 8'h90)));
        end else if (sel == 1) begin
          add_byte(8'hF4);
          add_byte(8'($urandom_range(8'h8F, 8'h80)));
        end else begin
          add_byte(8'($urandom_range(8'hF3, 8'hF1)));
          add_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
      end
    endcase
    // closing continuation byte
    add_byte(8'($urandom_range(8'hBF, 8'h80)));
  endtask

  // A random text: mostly words, delimiters, escapes and valid UTF-8, some broken bytes.
  task automatic build_text();
    int unsigned cps, pick;
    text_q.delete();
    cps = $urandom_range(10, 1);
    repeat (cps) begin
      pick = $urandom_range(99);
      if (pick < 25)      add_byte(8'($urandom_range(127)));
      else if (pick < 45) add_byte(8'("a" + $urandom_range(25)));
      else if (pick < 60) add_byte(utp_pkg::BACKSLASH);
      else if (pick < 68) add_byte(" ");
      else if (pick < 88) add_multibyte();
      else if (pick < 94) add_byte(8'($urandom_range(8'hFF, 8'h80)));
      else begin
        // truncated sequence
        add_multibyte();
        void'(text_q.pop_back());
      end
    end
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
  endtask

  // Backslash and space are delimiters here; letters are not.
  task automatic send_directed();
    // word, dropped space, word
    send_item("a", 1'b0);
    send_item(" ", 1'b0);
    send_item("b", 1'b0);
    // escaped delimiter joins the open token
    send_item(utp_pkg::BACKSLASH, 1'b0);
    send_item(" ", 1'b0);
    // escaped non-delimiter splits because backslash is a delimiter
    send_item(utp_pkg::BACKSLASH, 1'b0);
    send_item("x", 1'b0);
    // escaped backslash
    send_item(utp_pkg::BACKSLASH, 1'b0);
    send_item(utp_pkg::BACKSLASH, 1'b0);
    // escaped 3-byte code point
    send_item(utp_pkg::BACKSLASH, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'h82, 1'b0);
    send_item(8'hAC, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
    // trailing backslash is an ordinary code point
    send_item(utp_pkg::BACKSLASH, 1'b1);
    // invalid lead, surrogate, above U+10FFFF, overlong, truncated at the end
    send_item(8'hFF, 1'b0);
    send_item(8'hED, 1'b0);
    send_item(8'hA0, 1'b0);
    send_item(8'hF4, 1'b0);
    send_item(8'h90, 1'b0);
    send_item(8'hE0, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hC3, 1'b1);
  endtask

  initial begin
    int unsigned target;
    logic [63:0] lo, hi;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Phases: typical punctuation, same without backslash, all, none, random, same without.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0:       begin lo = PUNCT_LOW;   hi = PUNCT_HIGH;      end
        1:       begin lo = PUNCT_LOW;   hi = PUNCT_HIGH_NOBS; end
        2:       begin lo = '1;          hi = '1;              end
        3:       begin lo = '0;          hi = '0;              end
        4:       begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom} | BS_BIT;  end
        default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom} & ~BS_BIT; end
      endcase
      load_maps(lo, hi);
      // one long stretch without any idling on either side
      steady <= (p == 2);
      if (p == 0) send_directed();
      target = sent + PHASE_BYTES;
      while (sent < target) begin
        build_text();
        send_text();
      end
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("[utf8_punctuation_tokenizer] OK");
    end else begin
      $display("[utf8_punctuation_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/utp_pkg.sv
rtl/utp_front.sv
rtl/utp_fifo.sv
rtl/utp_back.sv
rtl/utf8_punctuation_tokenizer.sv
rtl/utp_checker.sv
tb/sv/utf8_punctuation_tokenizer_checker.sv
tb/sv/tb.sv
